// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property check on the block clock
`define DGBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DGBA_ASSERT_IMP(lbl, ante, cons, msg) \
  `DGBA_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define DGBA_ASSERT_NXT(lbl, ante, cons, msg) \
  `DGBA_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define DGBA_ASSERT(lbl, prop, msg)
`define DGBA_ASSERT_IMP(lbl, ante, cons, msg)
`define DGBA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/dgba_pkg.sv =====
// ----------------------------------------------------------------------------
// dgba_pkg
// Types, constants and arithmetic helpers of the two-image gray/alpha encoder.
// ----------------------------------------------------------------------------
package dgba_pkg;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned GAIN_W     = 14;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SCALED_W   = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned GAIN_SHIFT = 12;
  localparam int unsigned LANE_DEPTH = 4;               // gray, lerp x, lerp y, gain
  localparam int unsigned PIPE_DEPTH = LANE_DEPTH + 1;  // plus merge/output register

  localparam logic [15:0]        GRAY_WR    = 16'd19595;
  localparam logic [15:0]        GRAY_WG    = 16'd38469;
  localparam logic [15:0]        GRAY_WB    = 16'd7472;
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 14'd4096;
  localparam logic [LEVEL_W-1:0] SPLIT_RESET = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_FIRST  = 2'd0,
    CFG_GAIN_SECOND = 2'd1,
    CFG_SPLIT_LEVEL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_first;
    logic [GAIN_W-1:0]  gain_second;
    logic [LEVEL_W-1:0] split_level;
  } cfg_regs_t;

  // pixel order: top left, top right, bottom left, bottom right
  typedef logic [3:0][PIX_W-1:0] pix_quad_t;

  // (19595 r + 38469 g + 7472 b) >> 16; sum stays below 2^24
  function automatic logic [7:0] to_gray(input logic [PIX_W-1:0] px);
    logic [23:0] acc;
    acc = 24'(px[7:0])   * 24'(GRAY_WR)
        + 24'(px[15:8])  * 24'(GRAY_WG)
        + 24'(px[23:16]) * 24'(GRAY_WB);
    return acc[23:16];
  endfunction

  // p + floor((q - p) * w / 256); result always lies between p and q
  function automatic logic [7:0] lerp8(input logic [7:0] p, input logic [7:0] q,
                                       input logic [FRAC_W-1:0] w);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [9:0]  step;
    logic [9:0]         sum;
    diff = $signed({1'b0, q}) - $signed({1'b0, p});
    prod = 18'(diff) * $signed({10'b0, w});
    step = 10'(prod >>> 8);
    sum  = {2'b00, p} + $unsigned(step);
    return sum[7:0];
  endfunction

endpackage

// ===== hw/rtl/dgba_in_if.sv =====
// ----------------------------------------------------------------------------
// dgba_in_if
// Input channel: two 2x2 RGB neighborhoods and their blend weights.
// ----------------------------------------------------------------------------
interface dgba_in_if import dgba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  a_top_left;
  logic [PIX_W-1:0]  a_top_right;
  logic [PIX_W-1:0]  a_bottom_left;
  logic [PIX_W-1:0]  a_bottom_right;
  logic [PIX_W-1:0]  b_top_left;
  logic [PIX_W-1:0]  b_top_right;
  logic [PIX_W-1:0]  b_bottom_left;
  logic [PIX_W-1:0]  b_bottom_right;
  logic [FRAC_W-1:0] a_x_frac;
  logic [FRAC_W-1:0] a_y_frac;
  logic [FRAC_W-1:0] b_x_frac;
  logic [FRAC_W-1:0] b_y_frac;

  modport source (
    output valid, a_top_left, a_top_right, a_bottom_left, a_bottom_right,
           b_top_left, b_top_right, b_bottom_left, b_bottom_right,
           a_x_frac, a_y_frac, b_x_frac, b_y_frac,
    input  ready
  );

  modport sink (
    input  valid, a_top_left, a_top_right, a_bottom_left, a_bottom_right,
           b_top_left, b_top_right, b_bottom_left, b_bottom_right,
           a_x_frac, a_y_frac, b_x_frac, b_y_frac,
    output ready
  );
endinterface

// ===== hw/rtl/dgba_out_if.sv =====
// ----------------------------------------------------------------------------
// dgba_out_if
// Output channel: gray level and alpha of one encoded pixel.
// ----------------------------------------------------------------------------
interface dgba_out_if import dgba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] gray_out;
  logic [LEVEL_W-1:0] alpha_out;

  modport source (output valid, gray_out, alpha_out, input ready);
  modport sink   (input valid, gray_out, alpha_out, output ready);
endinterface

// ===== hw/rtl/dgba_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dgba_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dgba_cfg_if import dgba_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dgba_lane.sv =====
// ----------------------------------------------------------------------------
// dgba_lane
// One image lane: gray conversion, bilinear blend and gain, four stages.
// ----------------------------------------------------------------------------
module dgba_lane import dgba_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  pix_quad_t           pix_i,
  input  logic [FRAC_W-1:0]   x_frac_i,
  input  logic [FRAC_W-1:0]   y_frac_i,
  input  logic [GAIN_W-1:0]   gain_i,
  output logic [SCALED_W-1:0] scaled_o
);

  logic [3:0][7:0]      gray_q, gray_d;
  logic [FRAC_W-1:0]    xw1_q, yw1_q, yw2_q;
  logic [7:0]           top_q, top_d, bot_q, bot_d;
  logic [7:0]           blend_q, blend_d;
  logic [SCALED_W-1:0]  scaled_q, scaled_d;
  logic [21:0]          prod;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      gray_d[k] = to_gray(pix_i[k]);
    end
    top_d    = lerp8(gray_q[0], gray_q[1], xw1_q);
    bot_d    = lerp8(gray_q[2], gray_q[3], xw1_q);
    blend_d  = lerp8(top_q, bot_q, yw2_q);
    prod     = {14'b0, blend_q} * {8'b0, gain_i};
    scaled_d = prod[GAIN_SHIFT +: SCALED_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gray_q   <= gray_d;
      xw1_q    <= x_frac_i;
      yw1_q    <= y_frac_i;
      top_q    <= top_d;
      bot_q    <= bot_d;
      yw2_q    <= yw1_q;
      blend_q  <= blend_d;
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

// ===== hw/rtl/dgba_merge.sv =====
// ----------------------------------------------------------------------------
// dgba_merge
// Clamps both lane results around the split level and forms gray and alpha.
// ----------------------------------------------------------------------------
module dgba_merge import dgba_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SCALED_W-1:0] first_i,
  input  logic [SCALED_W-1:0] second_i,
  input  logic [LEVEL_W-1:0]  split_i,
  output logic [LEVEL_W-1:0]  gray_o,
  output logic [LEVEL_W-1:0]  alpha_o
);

  logic [LEVEL_W-1:0] v1, v2;
  logic [LEVEL_W-1:0] gray_q, gray_d, alpha_q, alpha_d;

  always_comb begin
    if (first_i < SCALED_W'(split_i)) begin
      v1 = split_i;
    end else if (first_i > SCALED_W'(FULL_SCALE)) begin
      v1 = FULL_SCALE;
    end else begin
      v1 = first_i[LEVEL_W-1:0];
    end
    if (second_i > SCALED_W'(split_i)) begin
      v2 = split_i;
    end else begin
      v2 = second_i[LEVEL_W-1:0];
    end
    // v1 >= split >= v2, so this never wraps
    gray_d  = v2;
    alpha_d = FULL_SCALE - v1 + v2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gray_q  <= gray_d;
      alpha_q <= alpha_d;
    end
  end

  assign gray_o  = gray_q;
  assign alpha_o = alpha_q;

endmodule

// ===== hw/rtl/dual_gray_bilinear_alpha_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// dual_gray_bilinear_alpha_encoder_unit
// Two-image gray blend encoder: one gray/alpha pixel per input beat.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  in_i    | in  | valid / ready   | 8 pixels (24b RGB), 4 blend weights (8b)
//  out_o   | out | valid / ready   | gray_out (8b), alpha_out (8b)
//  cfg_i   | in  | valid / ready   | index (2b), data (14b); ready always high
//
//  one beat per cycle while the output is not stalled; each beat passes through
//  the gray, lerp x, lerp y and gain stages in two parallel lanes, then merge
//  the whole pipeline advances together when the output register is empty
//  or being taken, so a stall holds every stage in place
//  reset clears the stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dual_gray_bilinear_alpha_encoder_unit import dgba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dgba_in_if.sink     in_i,
  dgba_out_if.source  out_o,
  dgba_cfg_if.sink    cfg_i
);

  cfg_regs_t             cfg_q, cfg_d;
  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic                  advance, in_fire;
  logic [SCALED_W-1:0]   scaled_a, scaled_b;
  pix_quad_t             pix_a, pix_b;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_GAIN_FIRST:  cfg_d.gain_first  = cfg_i.data[GAIN_W-1:0];
        CFG_GAIN_SECOND: cfg_d.gain_second = cfg_i.data[GAIN_W-1:0];
        CFG_SPLIT_LEVEL: cfg_d.split_level = cfg_i.data[LEVEL_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // pipeline control
  assign advance     = !vld_q[PIPE_DEPTH-1] || out_o.ready;
  assign in_i.ready  = advance;
  assign in_fire     = in_i.valid && advance;
  assign out_o.valid = vld_q[PIPE_DEPTH-1];

  always_comb begin
    vld_d = vld_q;
    if (advance) begin
      vld_d = {vld_q[PIPE_DEPTH-2:0], in_fire};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain_first: GAIN_RESET, gain_second: GAIN_RESET,
                 split_level: SPLIT_RESET};
      vld_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      vld_q <= vld_d;
    end
  end

  assign pix_a = {in_i.a_bottom_right, in_i.a_bottom_left, in_i.a_top_right, in_i.a_top_left};
  assign pix_b = {in_i.b_bottom_right, in_i.b_bottom_left, in_i.b_top_right, in_i.b_top_left};

  dgba_lane u_lane_a (
    .clk_i    (clk_i),
    .en_i     (advance),
    .pix_i    (pix_a),
    .x_frac_i (in_i.a_x_frac),
    .y_frac_i (in_i.a_y_frac),
    .gain_i   (cfg_q.gain_first),
    .scaled_o (scaled_a)
  );

  dgba_lane u_lane_b (
    .clk_i    (clk_i),
    .en_i     (advance),
    .pix_i    (pix_b),
    .x_frac_i (in_i.b_x_frac),
    .y_frac_i (in_i.b_y_frac),
    .gain_i   (cfg_q.gain_second),
    .scaled_o (scaled_b)
  );

  dgba_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (advance),
    .first_i  (scaled_a),
    .second_i (scaled_b),
    .split_i  (cfg_q.split_level),
    .gray_o   (out_o.gray_out),
    .alpha_o  (out_o.alpha_out)
  );

  // assertions
  `DGBA_ASSERT_NXT(a_fire_enters, in_fire, vld_q[0], "accepted beat did not enter the pipeline")
  `DGBA_ASSERT_NXT(a_stall_holds, out_o.valid && !out_o.ready, $stable(vld_q), "pipeline moved during a stall")
  `DGBA_ASSERT_IMP(a_gray_ceiling, out_o.valid, out_o.gray_out <= cfg_q.split_level, "gray above split level")

endmodule
